// ----- design/nbsp_pkg.sv -----
`default_nettype none
package nbsp_pkg;

   // Command codes carried from the front end to the back end
   localparam logic [1:0] OP_PACK = 2'd0;  // pack one 9-bit word
   localparam logic [1:0] OP_PAD  = 2'd1;  // pad the group with NOP words, end transfer
   localparam logic [1:0] OP_MARK = 2'd2;  // group already full: bare end marker

   localparam logic [7:0] NOP_BYTE   = 8'h00;
   localparam logic [2:0] GROUP_LAST = 3'd7;

   typedef struct packed {
      logic       req_type;
      logic       dc_bit;
      logic [7:0] data_byte;
   } nbsp_req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       byte_valid;
      logic       last;
   } nbsp_rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic       dc_bit;
      logic [7:0] data_byte;
   } nbsp_cmd_type;

endpackage
`default_nettype wire

// ----- design/nbsp_front.sv -----
`default_nettype none
module nbsp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  nbsp_pkg::nbsp_req_type req_data,
   input  wire                   q_full,
   output logic                  q_push,
   output nbsp_pkg::nbsp_cmd_type q_cmd
);
   import nbsp_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       pending_ff, pending_in;
   logic       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      pos_in           = pos_ff;
      pending_in       = pending_ff;
      q_push           = 1'b0;
      q_cmd.op         = OP_PACK;
      q_cmd.dc_bit     = req_data.dc_bit;
      q_cmd.data_byte  = req_data.data_byte;
      if (accept) begin
         if (!req_data.req_type) begin
            q_push     = 1'b1;
            pos_in     = pos_ff + 3'd1;
            pending_in = 1'b1;
         end else if (pending_ff) begin
            // flush: full group needs only a marker, partial group needs padding
            q_push     = 1'b1;
            q_cmd.op   = (pos_ff == 3'd0) ? OP_MARK : OP_PAD;
            pos_in     = 3'd0;
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 3'd0;
         pending_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/nbsp_fifo.sv -----
`default_nettype none
module nbsp_fifo #(
   parameter int QDEPTH = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  nbsp_pkg::nbsp_cmd_type push_cmd,
   output logic                  full,
   input  wire                   pop,
   output logic                  head_valid,
   output nbsp_pkg::nbsp_cmd_type head_cmd
);
   import nbsp_pkg::*;

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

   nbsp_cmd_type    entry_ff [QDEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full       = (cnt_ff == CNT_FULL);
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

// ----- design/nbsp_back.sv -----
`default_nettype none
module nbsp_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_valid,
   input  nbsp_pkg::nbsp_cmd_type q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output nbsp_pkg::nbsp_rsp_type rsp_data
);
   import nbsp_pkg::*;

   logic [7:0]   residual_ff, residual_in;
   logic [2:0]   pos_ff, pos_in;
   logic         pad_ff, pad_in;
   logic         tail_ff, tail_in;
   logic [7:0]   tail_byte_ff, tail_byte_in;
   logic         tail_last_ff, tail_last_in;
   logic         rsp_valid_ff, rsp_valid_in;
   nbsp_rsp_type rsp_data_ff, rsp_data_in;

   logic         out_free, word_go, is_pad;
   logic [16:0]  acc;
   logic [3:0]   sh;
   logic [7:0]   mask;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = out_free && !tail_ff && !pad_ff && q_valid;
   assign word_go  = (out_free && !tail_ff && pad_ff) || (q_pop && q_cmd.op != OP_MARK);
   assign is_pad   = pad_ff || (q_cmd.op == OP_PAD);
   assign acc      = is_pad ? {residual_ff, 1'b0, NOP_BYTE}
                            : {residual_ff, q_cmd.dc_bit, q_cmd.data_byte};
   assign sh       = {1'b0, pos_ff} + 4'd1;
   assign mask     = ~(8'hFF << sh);

   always_comb begin
      residual_in  = residual_ff;
      pos_in       = pos_ff;
      pad_in       = pad_ff;
      tail_in      = tail_ff;
      tail_byte_in = tail_byte_ff;
      tail_last_in = tail_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (out_free && tail_ff) begin
         // second byte of the eighth word
         tail_in                 = 1'b0;
         rsp_valid_in            = 1'b1;
         rsp_data_in.packed_byte = tail_byte_ff;
         rsp_data_in.byte_valid  = 1'b1;
         rsp_data_in.last        = tail_last_ff;
      end else if (word_go) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.byte_valid = 1'b1;
         rsp_data_in.last       = 1'b0;
         if (pos_ff == GROUP_LAST) begin
            rsp_data_in.packed_byte = acc[15:8];
            tail_in      = 1'b1;
            tail_byte_in = acc[7:0];
            tail_last_in = is_pad;
            pad_in       = 1'b0;
            pos_in       = 3'd0;
            residual_in  = 8'd0;
         end else begin
            rsp_data_in.packed_byte = 8'(acc >> sh);
            residual_in  = acc[7:0] & mask;
            pos_in       = pos_ff + 3'd1;
            pad_in       = is_pad;
         end
      end else if (q_pop && q_cmd.op == OP_MARK) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.packed_byte = 8'd0;
         rsp_data_in.byte_valid  = 1'b0;
         rsp_data_in.last        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residual_ff  <= 8'd0;
         pos_ff       <= 3'd0;
         pad_ff       <= 1'b0;
         tail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         residual_ff  <= residual_in;
         pos_ff       <= pos_in;
         pad_ff       <= pad_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_byte_ff <= tail_byte_in;
      tail_last_ff <= tail_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- design/nine_bit_spi_word_packer.sv -----
// Path: a byte request is written into the command queue, then popped by the back end, whose
// output register offers its first packed byte on rsp.
// Throughput: one byte request per cycle while the queue is not full; the eighth word of a
// group gives two bytes. A flush pads the group with NOP words, a bare end marker is one result;
// the back end's single output register emits one result per cycle while rsp_stall is low.
// Reset: synchronous, active high; clears queue, residue, group position and pending state.
`default_nettype none
module nine_bit_spi_word_packer #(
   parameter int QDEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  nbsp_pkg::nbsp_req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output nbsp_pkg::nbsp_rsp_type rsp_data
);
   import nbsp_pkg::*;

   // Front end classifies each request (pack, pad flush, marker flush, or an empty
   // flush that is dropped) and tracks its own copy of group position and pending.
   logic         q_push, q_full, q_pop, q_valid;
   nbsp_cmd_type push_cmd, head_cmd;

   nbsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   // Short command queue decouples accepting requests from emitting bytes,
   // so byte requests keep flowing while a flush pads or the output stalls, until the queue fills.
   nbsp_fifo #(.QDEPTH(QDEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   // Back end owns the residual bits, packs one 9-bit word per cycle while the output is free and
   // no tail byte is pending, and drives the registered output of each transfer.
   nbsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- design/nbsp_checker.sv -----
`default_nettype none
module nbsp_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input nbsp_pkg::nbsp_req_type req_data,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input nbsp_pkg::nbsp_rsp_type rsp_data
);
   import nbsp_pkg::*;

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a bare marker always closes the transfer and carries no byte
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.last && rsp_data.packed_byte == 8'd0)
      else $error("bad end marker");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

   // empty after reset: with no transfer in on the first edge, nothing can come out next
   a_quiet_start: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result without a request");

   // no unknown bits on an offered result
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("unknown result bits");

endmodule

bind nine_bit_spi_word_packer nbsp_checker u_nbsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
